>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SPS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked in every cycle, reset included.
`define SPS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

>>> rtl/sps_pkg.sv
// Shared types, constants and helpers of the strict priority shaper.
`timescale 1ns / 1ps
package sps_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int MAX_RELEASE_DEF = 64;
  localparam int NUM_QUEUES      = 2;
  localparam int BYTES_W         = 24;
  localparam int US_W            = 20;
  localparam int DVD_W           = 48;
  localparam int DIV_STEPS       = 6;
  localparam int CFG_IDX_W       = 3;

  localparam logic [31:0] RATE_RESET   = 32'd1176500000;
  localparam logic [31:0] BUCKET_RESET = 32'd360000;
  localparam logic [31:0] THRESH_RESET = 32'd150000;
  localparam logic [5:0]  DSCP_RESET   = 6'd1;
  localparam logic [15:0] ALLOW_RESET  = 16'd52;
  localparam logic [1:0]  ECN_BITS     = 2'h3;
  localparam logic [1:0]  ECN_ECT1     = 2'h1;
  localparam logic [1:0]  ECN_ECT0     = 2'h2;
  // one million is 64 * 15625; floor(2^44 / 15625)
  localparam logic [13:0] DIV_D        = 14'd15625;
  localparam logic [30:0] DIV_RECIP    = 31'd1125899906;

  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DSCP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW  = 3'd5;

  typedef enum logic [2:0] {
    ACT_SENT     = 3'd0,
    ACT_QUEUED   = 3'd1,
    ACT_DROPPED  = 3'd2,
    ACT_RELEASED = 3'd3,
    ACT_IDLE     = 3'd4
  } action_t;

  typedef struct packed {
    logic            mode;
    logic [15:0]     pkt_tag;
    logic [15:0]     pkt_len;
    logic [7:0]      tos_in;
    logic            eligible;
    logic [US_W-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] out_tag;
    logic        queue_index;
    logic [7:0]  tos_out;
    logic        ecn_marked;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic arrive;
    logic mul0;
    logic mul1;
    logic dload;
    logic dstep;
    logic add;
    logic rd;
    logic rel;
    logic next_q;
    logic fin;
  } sps_cmd_t;

  typedef struct packed {
    logic div_last;
    logic cnt_zero;
    logic n_full;
    logic qsel;
    logic fits;
  } sps_stat_t;

  function automatic logic [15:0] charge_of(input logic [15:0] len,
                                            input logic [15:0] allow);
    return (len > allow) ? len - allow : len;
  endfunction

endpackage

>>> rtl/sps_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/sps_ctrl.sv
// Controller state machine of the shaper.
`timescale 1ns / 1ps
module sps_ctrl import sps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      mode,
  input  sps_stat_t stat,
  output sps_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ARRIVE = 10'b0000000010,
    S_MUL0   = 10'b0000000100,
    S_MUL1   = 10'b0000001000,
    S_DLOAD  = 10'b0000010000,
    S_DIV    = 10'b0000100000,
    S_ADD    = 10'b0001000000,
    S_RD     = 10'b0010000000,
    S_CHK    = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = mode ? S_MUL0 : S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        cmd.arrive = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.dload = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (!stat.n_full && !stat.cnt_zero) begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHK;
        end else if (!stat.qsel) begin
          cmd.next_q = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CHK: begin
        if (stat.fits) begin
          cmd.rel   = 1'b1;
          state_nxt = S_RD;
        end else if (!stat.qsel) begin
          cmd.next_q = 1'b1;
          state_nxt  = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sps_dp.sv
// Datapath: config registers, queue state, token bucket, divider, result register.
`timescale 1ns / 1ps
module sps_dp import sps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_RELEASE = MAX_RELEASE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  sps_cmd_t             cmd,
  output sps_stat_t            stat,
  output logic                 out_valid,
  output out_item_t            out_data
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int NW = $clog2(MAX_RELEASE + 1);
  localparam logic [CW:0]   QD_S = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] QD_A = AW'(QUEUE_DEPTH);
  localparam logic [QW:0]   QD_H = (QW + 1)'(QUEUE_DEPTH);

  logic [31:0] rate_r, bucket_r, thr_r;
  logic        port_r;
  logic [5:0]  dscp_r;
  logic [15:0] allow_r;

  logic [31:0]        tok_r, tok_nxt;
  logic [QW-1:0]      head_r [NUM_QUEUES];
  logic [QW-1:0]      head_nxt [NUM_QUEUES];
  logic [CW-1:0]      cnt_r [NUM_QUEUES];
  logic [CW-1:0]      cnt_nxt [NUM_QUEUES];
  logic [BYTES_W-1:0] bytes_r [NUM_QUEUES];
  logic [BYTES_W-1:0] bytes_nxt [NUM_QUEUES];

  in_item_t          item_r;
  logic [35:0]       plo_r, phi_r;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [13:0]       rem_r, rem_nxt;
  logic [29:0]       dt_r;
  logic [15:0]       dq_r;
  logic [5:0]        dcnt_r, dcnt_nxt;
  logic              qsel_r, qsel_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic              pend_r, pend_nxt;
  logic [15:0]       ptag_r, ptag_nxt;
  logic              pq_r, pq_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         out_r, out_nxt;

  // arrival
  logic               qi, ahead_zero, send, over, mark, full;
  logic [BYTES_W:0]   backlog;
  logic [7:0]         tos_m;
  logic [CW:0]        slot_s, slot_w;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               wr_en;
  logic [31:0]        rd_data;
  logic [15:0]        rd_len, rd_chg, arr_chg;
  logic [51:0]        prod_sum;
  logic [29:0]        dig_t, dig_r0;
  logic [60:0]        dig_p;
  logic               dig_fix;
  logic [15:0]        dig_q;
  logic [33:0]        tok_sum;
  logic [QW:0]        head_inc;

  assign qi         = (item_r.tos_in[7:2] == dscp_r) ? 1'b0 : 1'b1;
  assign ahead_zero = (cnt_r[0] == '0) && (!qi || (cnt_r[1] == '0));
  assign send       = ahead_zero && (tok_r >= {16'd0, item_r.pkt_len});
  assign backlog    = port_r ? ({1'b0, bytes_r[0]} + {1'b0, bytes_r[1]})
                             : {1'b0, bytes_r[qi]};
  assign over       = {7'd0, backlog} > thr_r;
  assign mark       = over && ((item_r.tos_in[1:0] == ECN_ECT1) ||
                               (item_r.tos_in[1:0] == ECN_ECT0));
  assign tos_m      = mark ? (item_r.tos_in | {6'd0, ECN_BITS}) : item_r.tos_in;
  assign full       = ({1'b0, cnt_r[qi]} == QD_S);
  assign slot_s     = (CW + 1)'(head_r[qi]) + (CW + 1)'(cnt_r[qi]);
  assign slot_w     = (slot_s >= QD_S) ? slot_s - QD_S : slot_s;
  assign wr_addr    = qi ? AW'(slot_w[QW-1:0]) + QD_A : AW'(slot_w[QW-1:0]);
  assign wr_en      = cmd.arrive && item_r.eligible && !send && !full;
  assign arr_chg    = charge_of(item_r.pkt_len, allow_r);

  // release
  assign rd_addr  = qsel_r ? AW'(head_r[1]) + QD_A : AW'(head_r[0]);
  assign rd_len   = rd_data[15:0];
  assign rd_chg   = charge_of(rd_len, allow_r);
  assign head_inc = (QW + 1)'(head_r[qsel_r]) + (QW + 1)'(1);

  // divide by one million: drop 6 bits, then 16-bit digits by 15625,
  // reciprocal estimate registered, then a single correction in the next cycle
  assign prod_sum = 52'(plo_r) + {phi_r, 16'd0};
  assign dig_t    = {rem_r, dvd_r[DVD_W-1:DVD_W-16]};
  assign dig_p    = 61'(dig_t) * 61'(DIV_RECIP);
  assign dig_r0   = dt_r - 30'(dq_r) * 30'(DIV_D);
  assign dig_fix  = dig_r0 >= 30'(DIV_D);
  assign dig_q    = dig_fix ? dq_r + 16'd1 : dq_r;
  assign tok_sum  = {2'd0, tok_r} + {1'b0, dvd_r[32:0]};

  assign stat.div_last = (dcnt_r == 6'(DIV_STEPS - 1));
  assign stat.cnt_zero = (cnt_r[qsel_r] == '0);
  assign stat.n_full   = (n_r == NW'(MAX_RELEASE));
  assign stat.qsel     = qsel_r;
  assign stat.fits     = ({16'd0, rd_chg} <= tok_r);

  assign out_valid = ov_r;
  assign out_data  = out_r;

  sps_ram #(.WIDTH(32), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({item_r.pkt_tag, item_r.pkt_len}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    tok_nxt   = tok_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    qsel_nxt  = qsel_r;
    n_nxt     = n_r;
    pend_nxt  = pend_r;
    ptag_nxt  = ptag_r;
    pq_nxt    = pq_r;
    ov_nxt    = 1'b0;
    out_nxt   = out_r;

    if (cmd.latch) begin
      qsel_nxt = 1'b0;
      n_nxt    = '0;
      pend_nxt = 1'b0;
    end

    if (cmd.arrive) begin
      ov_nxt  = 1'b1;
      out_nxt = '{action: ACT_SENT, out_tag: item_r.pkt_tag, queue_index: 1'b0,
                  tos_out: item_r.tos_in, ecn_marked: 1'b0, last_of_run: 1'b1};
      if (item_r.eligible) begin
        out_nxt.queue_index = qi;
        if (send) begin
          tok_nxt = tok_r - {16'd0, arr_chg};
        end else begin
          out_nxt.tos_out    = tos_m;
          out_nxt.ecn_marked = mark;
          if (full) begin
            out_nxt.action = ACT_DROPPED;
          end else begin
            out_nxt.action = ACT_QUEUED;
            cnt_nxt[qi]    = cnt_r[qi] + CW'(1);
            bytes_nxt[qi]  = bytes_r[qi] + BYTES_W'(item_r.pkt_len);
          end
        end
      end
    end

    if (cmd.dload) begin
      dvd_nxt  = {2'd0, prod_sum[51:6]};
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end

    if (cmd.dstep) begin
      dcnt_nxt = dcnt_r + 6'd1;
      if (dcnt_r[0]) begin
        rem_nxt = dig_fix ? 14'(dig_r0 - 30'(DIV_D)) : dig_r0[13:0];
        dvd_nxt = {dvd_r[DVD_W-17:0], dig_q};
      end
    end

    if (cmd.add) begin
      tok_nxt = (tok_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : tok_sum[31:0];
    end

    if (cmd.next_q) begin
      qsel_nxt = 1'b1;
    end

    if (cmd.rel) begin
      tok_nxt           = tok_r - {16'd0, rd_chg};
      head_nxt[qsel_r]  = (head_inc == QD_H) ? '0 : head_inc[QW-1:0];
      cnt_nxt[qsel_r]   = cnt_r[qsel_r] - CW'(1);
      bytes_nxt[qsel_r] = bytes_r[qsel_r] - BYTES_W'(rd_len);
      n_nxt             = n_r + NW'(1);
      pend_nxt          = 1'b1;
      ptag_nxt          = rd_data[31:16];
      pq_nxt            = qsel_r;
      if (pend_r) begin
        ov_nxt  = 1'b1;
        out_nxt = '{action: ACT_RELEASED, out_tag: ptag_r, queue_index: pq_r,
                    tos_out: 8'd0, ecn_marked: 1'b0, last_of_run: 1'b0};
      end
    end

    if (cmd.fin) begin
      if ((cnt_r[0] == '0) && (cnt_r[1] == '0) && (tok_r >= bucket_r)) begin
        tok_nxt = bucket_r;
      end
      ov_nxt = 1'b1;
      if (pend_r) begin
        out_nxt = '{action: ACT_RELEASED, out_tag: ptag_r, queue_index: pq_r,
                    tos_out: 8'd0, ecn_marked: 1'b0, last_of_run: 1'b1};
      end else begin
        out_nxt = '{action: ACT_IDLE, out_tag: 16'd0, queue_index: 1'b0,
                    tos_out: 8'd0, ecn_marked: 1'b0, last_of_run: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RESET;
      bucket_r <= BUCKET_RESET;
      thr_r    <= THRESH_RESET;
      port_r   <= 1'b1;
      dscp_r   <= DSCP_RESET;
      allow_r  <= ALLOW_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RATE:   rate_r   <= cfg_wdata;
        REG_BUCKET: bucket_r <= cfg_wdata;
        REG_THRESH: thr_r    <= cfg_wdata;
        REG_PORT:   port_r   <= cfg_wdata[0];
        REG_DSCP:   dscp_r   <= cfg_wdata[5:0];
        REG_ALLOW:  allow_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= BUCKET_RESET;
      head_r    <= '{default: '0};
      cnt_r     <= '{default: '0};
      bytes_r   <= '{default: '0};
      ov_r      <= 1'b0;
      pend_r    <= 1'b0;
      qsel_r    <= 1'b0;
      n_r       <= '0;
      dcnt_r    <= '0;
    end else begin
      tok_r     <= tok_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      bytes_r   <= bytes_nxt;
      ov_r      <= ov_nxt;
      pend_r    <= pend_nxt;
      qsel_r    <= qsel_nxt;
      n_r       <= n_nxt;
      dcnt_r    <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.mul0) begin
      plo_r <= item_r.elapsed_us * rate_r[15:0];
    end
    if (cmd.mul1) begin
      phi_r <= item_r.elapsed_us * rate_r[31:16];
    end
    if (cmd.dstep && !dcnt_r[0]) begin
      dt_r <= dig_t;
      dq_r <= dig_p[59:44];
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    ptag_r <= ptag_nxt;
    pq_r   <= pq_nxt;
    out_r  <= out_nxt;
  end

endmodule

>>> rtl/strict_priority_shaper_ecn.sv
// Top level of the strict priority token bucket shaper with ECN marking.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; results appear on
// out_data for one cycle each, marked by out_valid, and must be taken as they
// come since the receiver cannot stall. A packet arrival keeps busy high for
// one cycle and gives its single result from the registered output. A tick
// runs the multiply states MUL0 and MUL1, the load state DLOAD, the divide
// by one million in DIV (per 16-bit quotient digit a reciprocal estimate,
// then a correction) and the token add in ADD, then per queue head examined
// a queue RAM read in RD and a check in CHK, a pass to the next queue where
// one is done, and the closing FIN; releases come out one per released head,
// the last flagged by last_of_run, or an idle result if none. Registers are
// written on any cycle cfg_wr_en is high, meant for when the block is idle.
module strict_priority_shaper_ecn import sps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_RELEASE = MAX_RELEASE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  sps_cmd_t  cmd;
  sps_stat_t stat;

  sps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_data.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sps_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_RELEASE(MAX_RELEASE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/sps_checker.sv
// Port level checks of the shaper and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sps_checker import sps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  `SPS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!busy && !out_valid))
  `SPS_ASSERT(a_take_busy, clk, rst_n, (start && !busy) |=> busy)
  `SPS_ASSERT(a_arrival_result, clk, rst_n, (start && !busy && !in_data.mode) |-> ##2 (out_valid && out_data.last_of_run))
  `SPS_ASSERT(a_single_last, clk, rst_n, (out_valid && out_data.action != ACT_RELEASED) |-> out_data.last_of_run)
  `SPS_ASSERT(a_idle_no_result, clk, rst_n, (out_valid && out_data.last_of_run) |=> !out_valid)

endmodule

bind strict_priority_shaper_ecn sps_checker u_sps_checker (.*);
